### rtl/core/enc_pkg.sv
// ----------------------------------------------------------------------------
// enc_pkg: shared types and constants for the Euler node clamp core
// Field widths, register indexes and the item formats that move between the
// front end, the item queue, the arithmetic back end and the result buffer.
// ----------------------------------------------------------------------------
package enc_pkg;

  localparam int LANES  = 3;
  localparam int NODE_W = 12;
  localparam int Q_W    = 32;
  localparam int NRM_W  = 16;
  localparam int LIM_W  = 31;
  localparam int IDX_W  = 3;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_STEP_FACTOR    = 3'd0;
  localparam logic [IDX_W-1:0] REG_STEP_LENGTH    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_DISP       = 3'd2;
  localparam logic [IDX_W-1:0] REG_NORMALIZE_MODE = 3'd3;
  localparam logic [IDX_W-1:0] REG_FORCE_CLAMP    = 3'd4;
  localparam logic [IDX_W-1:0] REG_TRACK_NORMAL   = 3'd5;

  // 1.0 in Q16.16
  localparam logic [LIM_W-1:0] ONE_Q16 = 31'd65536;

  // Item queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [NODE_W-1:0]            node_id;
    logic [LANES-1:0][Q_W-1:0]    vec;      // gradient, then displacement
    logic [LANES-1:0][NRM_W-1:0]  nrm;
    logic [LIM_W-1:0]             lim;
    logic                         clamp;    // clamp enabled, later: clamped
    logic                         track;
    logic                         inb;      // node inside the store
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0]            node_id;
    logic [LANES-1:0][Q_W-1:0]    disp;
    logic [Q_W-1:0]               total;
    logic                         clamped;
  } res_t;

endpackage

### rtl/core/enc_queue.sv
// ----------------------------------------------------------------------------
// enc_queue: short item queue between front end and back end
// Show-ahead register queue; the head entry is always on q_head.
// ----------------------------------------------------------------------------
module enc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  enc_pkg::item_t  push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output enc_pkg::item_t  q_head
);
  import enc_pkg::*;

  item_t             ent_r [QDEPTH];
  logic [QAW-1:0]    wp_r, rp_r;
  logic [QAW:0]      cnt_r;

  assign full      = (cnt_r == (QAW+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign q_head    = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/core/enc_front.sv
// ----------------------------------------------------------------------------
// enc_front: configuration registers and item classification
// Accept nodes, pick the displacement limit and the clamp enable, flag nodes
// outside the store, and push the classified item into the queue.
// ----------------------------------------------------------------------------
module enc_front #(
  parameter int NODES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [enc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_push,
  input  logic [enc_pkg::NODE_W-1:0]    in_node_id,
  input  logic signed [enc_pkg::Q_W-1:0]   in_grad_x,
  input  logic signed [enc_pkg::Q_W-1:0]   in_grad_y,
  input  logic signed [enc_pkg::Q_W-1:0]   in_grad_z,
  input  logic signed [enc_pkg::NRM_W-1:0] in_normal_x,
  input  logic signed [enc_pkg::NRM_W-1:0] in_normal_y,
  input  logic signed [enc_pkg::NRM_W-1:0] in_normal_z,
  input  logic                          q_full,
  input  logic                          busy,
  output logic                          in_full,
  output logic                          q_push,
  output enc_pkg::item_t                q_item,
  output logic signed [enc_pkg::Q_W-1:0]   step_factor
);
  import enc_pkg::*;

  logic signed [Q_W-1:0] step_factor_r;
  logic [LIM_W-1:0]      step_length_r;
  logic [LIM_W-1:0]      max_disp_r;
  logic                  normalize_mode_r;
  logic                  force_clamp_r;
  logic                  track_normal_r;
  logic [LIM_W-1:0]      lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_factor_r    <= -32'sd65536;
      step_length_r    <= ONE_Q16;
      max_disp_r       <= '0;
      normalize_mode_r <= 1'b1;
      force_clamp_r    <= 1'b0;
      track_normal_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP_FACTOR:    step_factor_r    <= cfg_data;
        REG_STEP_LENGTH:    step_length_r    <= cfg_data[LIM_W-1:0];
        REG_MAX_DISP:       max_disp_r       <= cfg_data[LIM_W-1:0];
        REG_NORMALIZE_MODE: normalize_mode_r <= cfg_data[0];
        REG_FORCE_CLAMP:    force_clamp_r    <= cfg_data[0];
        REG_TRACK_NORMAL:   track_normal_r   <= cfg_data[0];
        default:            step_factor_r    <= step_factor_r;
      endcase
    end
  end

  assign step_factor = step_factor_r;
  assign in_full     = q_full | busy;
  assign q_push      = in_push & ~in_full;

  always_comb begin
    if (max_disp_r != '0) begin
      lim = max_disp_r;
    end else if (normalize_mode_r) begin
      lim = step_length_r;
    end else begin
      lim = ONE_Q16;
    end
    q_item.node_id = in_node_id;
    q_item.vec[0]  = in_grad_x;
    q_item.vec[1]  = in_grad_y;
    q_item.vec[2]  = in_grad_z;
    q_item.nrm[0]  = in_normal_x;
    q_item.nrm[1]  = in_normal_y;
    q_item.nrm[2]  = in_normal_z;
    q_item.lim     = lim;
    q_item.clamp   = force_clamp_r | ~normalize_mode_r | (lim < step_length_r);
    q_item.track   = track_normal_r;
    q_item.inb     = (32'(in_node_id) < 32'(NODES));
  end

endmodule

### rtl/core/enc_back.sv
// ----------------------------------------------------------------------------
// enc_back: displacement arithmetic and per-node normal total store
// Scale, magnitude test, pipelined square root and divide, normal dot
// product, and read-modify-write of the running total with forwarding.
// ----------------------------------------------------------------------------
module enc_back #(
  parameter int NODES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic signed [enc_pkg::Q_W-1:0] step_factor,
  input  logic                          q_valid,
  input  enc_pkg::item_t                q_head,
  output logic                          q_pop,
  output logic                          busy,
  output logic                          res_valid,
  output enc_pkg::res_t                 res
);
  import enc_pkg::*;

  localparam int AW        = $clog2(NODES);
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 31;
  localparam int NUM_W     = 62;
  localparam int MAG_W     = 32;
  localparam int S_SQ0     = 5;
  localparam int S_DIV0    = S_SQ0 + SQ_STEPS;
  localparam int S_FIN     = S_DIV0 + DIV_STEPS;
  localparam int S_PRD     = S_FIN + 1;
  localparam int S_OUT     = S_PRD + 1;
  localparam int TOT       = S_OUT + 1;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [64:0] v);
    logic signed [Q_W-1:0] r;
    if (v > 65'sh7FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -65'sh80000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  // Pipeline registers
  logic [TOT-1:0]         vld_r;
  item_t                  itm_r   [TOT];
  item_t                  itm_in  [TOT];
  logic signed [63:0]     prod_r  [LANES];
  logic signed [63:0]     prod_in [LANES];
  logic [63:0]            sq_r    [LANES];
  logic [63:0]            sq_in   [LANES];
  logic [NUM_W-1:0]       num3_r  [LANES];
  logic [NUM_W-1:0]       num3_in [LANES];
  logic [NUM_W-1:0]       num4_r  [LANES];
  logic [NUM_W-1:0]       num5_r  [LANES];
  logic [NUM_W-1:0]       lim2_r, lim2_4_r, lim2_in;
  logic [63:0]            mag4_r, mag5_r, mag_in;
  logic [63:0]            sv_r   [SQ_STEPS];
  logic [63:0]            sr_r   [SQ_STEPS];
  logic [63:0]            sv_in  [SQ_STEPS];
  logic [63:0]            sr_in  [SQ_STEPS];
  logic [63:0]            vsrc   [SQ_STEPS];
  logic [63:0]            rsrc   [SQ_STEPS];
  logic [63:0]            sbit;
  logic [NUM_W-1:0]       snum_r [SQ_STEPS][LANES];
  logic [MAG_W-1:0]       ddiv_r [DIV_STEPS];
  logic [MAG_W-1:0]       dv_src [DIV_STEPS];
  logic [MAG_W-1:0]       drem_r [DIV_STEPS][LANES];
  logic [MAG_W-1:0]       drem_in[DIV_STEPS][LANES];
  logic [MAG_W-1:0]       dr_src [DIV_STEPS][LANES];
  logic [LIM_W-1:0]       dquo_r [DIV_STEPS][LANES];
  logic [LIM_W-1:0]       dquo_in[DIV_STEPS][LANES];
  logic [LIM_W-1:0]       dq_src [DIV_STEPS][LANES];
  logic [LIM_W-1:0]       dnum_r [DIV_STEPS][LANES];
  logic [LIM_W-1:0]       dnum_in[DIV_STEPS][LANES];
  logic [LIM_W-1:0]       dn_src [DIV_STEPS][LANES];
  logic [MAG_W:0]         dsh;
  logic signed [47:0]     nprod_r [LANES];
  logic signed [47:0]     nprod_in[LANES];
  logic signed [49:0]     dsum;
  logic signed [35:0]     dotr_r, dotr_in;
  logic [Q_W-1:0]         rdata_r;
  logic                   fwd_r, fwd_in;
  logic signed [Q_W-1:0]  last_r;
  logic signed [64:0]     rnd;
  logic [Q_W-1:0]         absd;
  logic signed [Q_W:0]    qs;
  logic signed [Q_W-1:0]  old;
  logic signed [Q_W-1:0]  tot;
  logic signed [36:0]     tsum;
  logic                   wr;
  logic [AW-1:0]          raddr, waddr;

  // Total store, cleared by a sweep after reset
  logic [Q_W-1:0]         mem [NODES];
  logic                   clr_r;
  logic [AW-1:0]          clr_cnt_r;

  assign busy  = clr_r;
  assign q_pop = en & q_valid & ~clr_r;

  always_comb begin
    // Default: carry the item down the pipe
    itm_in[0] = q_head;
    for (int k = 1; k < TOT; k++) begin
      itm_in[k] = itm_r[k-1];
    end

    for (int i = 0; i < LANES; i++) begin
      // Scale
      prod_in[i] = step_factor * $signed(q_head.vec[i]);
      // Round half up and saturate
      rnd = 65'(prod_r[i]) + 65'sd32768;
      itm_in[1].vec[i] = sat32(rnd >>> 16);
      // Magnitude terms
      absd = itm_r[1].vec[i][Q_W-1] ? (~itm_r[1].vec[i] + 1'b1) : itm_r[1].vec[i];
      sq_in[i]   = 64'(absd) * 64'(absd);
      num3_in[i] = NUM_W'(64'(absd) * 64'(itm_r[1].lim));
    end
    lim2_in = NUM_W'(64'(itm_r[1].lim) * 64'(itm_r[1].lim));
    mag_in  = sq_r[0] + sq_r[1] + sq_r[2];
    itm_in[4].clamp = itm_r[3].clamp & (mag4_r > {2'b00, lim2_4_r});

    // Square root, one result bit per stage
    vsrc[0] = mag5_r;
    rsrc[0] = '0;
    for (int k = 1; k < SQ_STEPS; k++) begin
      vsrc[k] = sv_r[k-1];
      rsrc[k] = sr_r[k-1];
    end
    for (int k = 0; k < SQ_STEPS; k++) begin
      sbit = 64'd1 << (62 - 2*k);
      if (vsrc[k] >= rsrc[k] + sbit) begin
        sv_in[k] = vsrc[k] - (rsrc[k] + sbit);
        sr_in[k] = (rsrc[k] >> 1) + sbit;
      end else begin
        sv_in[k] = vsrc[k];
        sr_in[k] = rsrc[k] >> 1;
      end
    end

    // Divide |d| * lim by the magnitude, one quotient bit per stage
    dv_src[0] = sr_r[SQ_STEPS-1][MAG_W-1:0];
    for (int i = 0; i < LANES; i++) begin
      dr_src[0][i] = MAG_W'(snum_r[SQ_STEPS-1][i][NUM_W-1:LIM_W]);
      dn_src[0][i] = snum_r[SQ_STEPS-1][i][LIM_W-1:0];
      dq_src[0][i] = '0;
    end
    for (int j = 1; j < DIV_STEPS; j++) begin
      dv_src[j] = ddiv_r[j-1];
      for (int i = 0; i < LANES; i++) begin
        dr_src[j][i] = drem_r[j-1][i];
        dn_src[j][i] = dnum_r[j-1][i];
        dq_src[j][i] = dquo_r[j-1][i];
      end
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int i = 0; i < LANES; i++) begin
        dsh = {dr_src[j][i], dn_src[j][i][LIM_W-1]};
        if (dsh >= {1'b0, dv_src[j]}) begin
          drem_in[j][i] = MAG_W'(dsh - {1'b0, dv_src[j]});
          dquo_in[j][i] = {dq_src[j][i][LIM_W-2:0], 1'b1};
        end else begin
          drem_in[j][i] = dsh[MAG_W-1:0];
          dquo_in[j][i] = {dq_src[j][i][LIM_W-2:0], 1'b0};
        end
        dnum_in[j][i] = {dn_src[j][i][LIM_W-2:0], 1'b0};
      end
    end

    // Apply the sign to the clamped magnitude
    for (int i = 0; i < LANES; i++) begin
      qs = {2'b00, dquo_r[DIV_STEPS-1][i]};
      if (itm_r[S_FIN-1].clamp) begin
        itm_in[S_FIN].vec[i] = itm_r[S_FIN-1].vec[i][Q_W-1] ? Q_W'(-qs) : Q_W'(qs);
      end
      nprod_in[i] = $signed(itm_r[S_FIN].vec[i]) * $signed(itm_r[S_FIN].nrm[i]);
    end

    // Dot product, rounded to Q16.16
    dsum    = nprod_r[0] + nprod_r[1] + nprod_r[2] + 50'sd8192;
    dotr_in = 36'(dsum >>> 14);
    raddr   = AW'(itm_r[S_PRD].node_id);
    fwd_in  = vld_r[S_OUT] & itm_r[S_OUT].track & itm_r[S_OUT].inb &
              (itm_r[S_OUT].node_id == itm_r[S_PRD].node_id);

    // Running total update
    old   = fwd_r ? last_r : $signed(rdata_r);
    tsum  = old + dotr_r;
    tot   = sat32(65'(tsum));
    waddr = AW'(itm_r[S_OUT].node_id);
    wr    = en & vld_r[S_OUT] & itm_r[S_OUT].track & itm_r[S_OUT].inb;
  end

  assign res_valid   = vld_r[S_OUT];
  assign res.node_id = itm_r[S_OUT].node_id;
  assign res.disp    = itm_r[S_OUT].vec;
  assign res.clamped = itm_r[S_OUT].clamp;
  assign res.total   = !itm_r[S_OUT].inb ? '0 : (itm_r[S_OUT].track ? tot : old);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[TOT-2:0], q_pop};
      end
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(NODES - 1)) begin
          clr_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < TOT; k++) begin
        itm_r[k] <= itm_in[k];
      end
      for (int i = 0; i < LANES; i++) begin
        prod_r[i]  <= prod_in[i];
        sq_r[i]    <= sq_in[i];
        num3_r[i]  <= num3_in[i];
        num4_r[i]  <= num3_r[i];
        num5_r[i]  <= num4_r[i];
        snum_r[0][i] <= num5_r[i];
        nprod_r[i] <= nprod_in[i];
      end
      lim2_r   <= lim2_in;
      lim2_4_r <= lim2_r;
      mag4_r   <= mag_in;
      mag5_r   <= mag4_r;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sv_r[k] <= sv_in[k];
        sr_r[k] <= sr_in[k];
      end
      for (int k = 1; k < SQ_STEPS; k++) begin
        for (int i = 0; i < LANES; i++) begin
          snum_r[k][i] <= snum_r[k-1][i];
        end
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        ddiv_r[j] <= dv_src[j];
        for (int i = 0; i < LANES; i++) begin
          drem_r[j][i] <= drem_in[j][i];
          dquo_r[j][i] <= dquo_in[j][i];
          dnum_r[j][i] <= dnum_in[j][i];
        end
      end
      dotr_r  <= dotr_in;
      fwd_r   <= fwd_in;
      rdata_r <= mem[raddr];
    end
    if (wr) begin
      last_r <= tot;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr) begin
      mem[waddr] <= tot;
    end
  end

endmodule

### rtl/core/euler_node_displacement_clamp_core.sv
// ----------------------------------------------------------------------------
// euler_node_displacement_clamp_core: explicit Euler node step with clamp
// Top level: front end, item queue, arithmetic back end, result buffer.
// ----------------------------------------------------------------------------
// Takes one mesh node per clock while in_full is low: the gradient is
// scaled by step_factor, the displacement limit and clamp enable are picked
// from the registers, a vector whose squared length exceeds the squared
// limit is rescaled to the limit through a 32-stage square root and a
// 31-stage divider, and with track_normal set the rounded dot product of
// displacement and normal is added to the node's saturated running total.
// Sustained rate is one node per cycle while the result buffer has room;
// a full buffer stalls the back end. Most stages are in the square root and
// divider. After reset the total store is swept to zero, one entry a cycle;
// in_full stays high during the sweep while configuration writes are taken
// as ever. Node ids at or above NODES leave the store alone and report a
// total of zero. Configure only while no transaction is in flight.
module euler_node_displacement_clamp_core #(
  parameter int NODES = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [enc_pkg::IDX_W-1:0]        cfg_index,
  input  logic [31:0]                      cfg_data,
  // node input
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [enc_pkg::NODE_W-1:0]       in_node_id,
  input  logic signed [enc_pkg::Q_W-1:0]   in_grad_x,
  input  logic signed [enc_pkg::Q_W-1:0]   in_grad_y,
  input  logic signed [enc_pkg::Q_W-1:0]   in_grad_z,
  input  logic signed [enc_pkg::NRM_W-1:0] in_normal_x,
  input  logic signed [enc_pkg::NRM_W-1:0] in_normal_y,
  input  logic signed [enc_pkg::NRM_W-1:0] in_normal_z,
  // results
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [enc_pkg::NODE_W-1:0]       out_node_id_out,
  output logic signed [enc_pkg::Q_W-1:0]   out_disp_x,
  output logic signed [enc_pkg::Q_W-1:0]   out_disp_y,
  output logic signed [enc_pkg::Q_W-1:0]   out_disp_z,
  output logic signed [enc_pkg::Q_W-1:0]   out_normal_total,
  output logic                             out_was_clamped
);
  import enc_pkg::*;

  logic                  q_full, q_push, q_pop, q_valid, busy;
  item_t                 q_item, q_head;
  logic signed [Q_W-1:0] step_factor;
  logic                  en, res_valid, ob_push, ob_pop;
  res_t                  res;
  res_t                  ob_r [2];
  logic                  ob_wp_r, ob_rp_r;
  logic [1:0]            ob_cnt_r;
  res_t                  head;

  // Registers take every write at once
  assign cfg_ready = 1'b1;

  enc_front #(.NODES(NODES)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_push     (in_push),
    .in_node_id  (in_node_id),
    .in_grad_x   (in_grad_x),
    .in_grad_y   (in_grad_y),
    .in_grad_z   (in_grad_z),
    .in_normal_x (in_normal_x),
    .in_normal_y (in_normal_y),
    .in_normal_z (in_normal_z),
    .q_full      (q_full),
    .busy        (busy),
    .in_full     (in_full),
    .q_push      (q_push),
    .q_item      (q_item),
    .step_factor (step_factor)
  );

  enc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .q_head    (q_head)
  );

  // Advance the back end only while the result buffer has a free slot, so a
  // finished result waits in the last stage while the buffer is full.
  assign en = (ob_cnt_r != 2'd2);

  enc_back #(.NODES(NODES)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .step_factor (step_factor),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .busy        (busy),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Two-entry result buffer; hold the oldest result on the ports
  assign ob_push   = en & res_valid;
  assign out_empty = (ob_cnt_r == 2'd0);
  assign ob_pop    = out_pop & ~out_empty;
  assign head      = ob_r[ob_rp_r];

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob_r[ob_wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wp_r  <= 1'b0;
      ob_rp_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      if (ob_push) begin
        ob_wp_r <= ~ob_wp_r;
      end
      if (ob_pop) begin
        ob_rp_r <= ~ob_rp_r;
      end
      case ({ob_push, ob_pop})
        2'b10:   ob_cnt_r <= ob_cnt_r + 1'b1;
        2'b01:   ob_cnt_r <= ob_cnt_r - 1'b1;
        default: ob_cnt_r <= ob_cnt_r;
      endcase
    end
  end

  assign out_node_id_out  = head.node_id;
  assign out_disp_x       = head.disp[0];
  assign out_disp_y       = head.disp[1];
  assign out_disp_z       = head.disp[2];
  assign out_normal_total = head.total;
  assign out_was_clamped  = head.clamped;

endmodule
